// ===== src/gpo_pkg.sv =====
// ============================================================================
// gpo_pkg
// Types and constants shared by the planar odometry filter and its CORDIC.
// ============================================================================
package gpo_pkg;

	// CORDIC angle table: atan(2^-i) on a 32-bit binary angle.
	localparam int AtanLen = 24;
	localparam logic [31:0] ATAN_TAB [AtanLen] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// Gain-compensated start value for sine and cosine, Q30.
	localparam logic signed [49:0] CORDIC_K = 50'sd652032874;

	// CORDIC operating modes.
	typedef enum logic {
		CM_VECTOR,
		CM_ROTATE
	} cordic_mode_t;

	// Sequencer states of the filter.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ATAN,
		ST_ATAN_WAIT,
		ST_SEED,
		ST_SC1,
		ST_SC1_WAIT,
		ST_ROT1,
		ST_SC2,
		ST_SC2_WAIT,
		ST_ROT2,
		ST_SUM,
		ST_DONE
	} state_t;

	// Request from the sequencer to the CORDIC.
	typedef struct packed {
		logic         start;
		cordic_mode_t mode;
		logic [15:0]  angle;
		logic [15:0]  vec_x;
		logic [15:0]  vec_y;
	} cordic_req_t;

	// Reply from the CORDIC.
	typedef struct packed {
		logic        done;
		logic [15:0] yaw;
		logic [15:0] cos_q14;
		logic [15:0] sin_q14;
	} cordic_rsp_t;

endpackage

// ===== src/gpo_cordic.sv =====
// ============================================================================
// gpo_cordic
// Iterative CORDIC: atan2 in vectoring mode, sine and cosine in rotation mode,
// one micro-rotation per cycle on a single shift-add datapath.
// ============================================================================
module gpo_cordic #(
	parameter int STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gpo_pkg::cordic_req_t req,
	output gpo_pkg::cordic_rsp_t rsp
);
	import gpo_pkg::*;

	localparam int NS = (STEPS < 1) ? 1 : ((STEPS > AtanLen) ? AtanLen : STEPS);
	localparam int IW = $clog2(NS + 1);
	localparam int DW = 50;

	logic                 busy_q;
	logic [IW-1:0]        idx_q;
	cordic_mode_t         mode_q;
	logic                 flip_q;
	logic signed [DW-1:0] x_q, y_q, z_q;
	logic                 done_q;
	logic signed [DW-1:0] xs, ys, x_n, y_n, z_n;
	logic                 dir_pos;
	logic signed [DW-1:0] at;
	logic signed [DW-1:0] vx, vy;
	logic [31:0]          ang;
	logic                 aflip;
	logic [31:0]          zrnd;
	logic signed [DW-1:0] cr, sr;

	// One micro-rotation step of the shared datapath.
	always_comb begin
		xs = x_q >>> idx_q;
		ys = y_q >>> idx_q;
		at = DW'(ATAN_TAB[5'(idx_q)]);
		dir_pos = (mode_q == CM_VECTOR) ? (y_q > 0) : (z_q >= 0);
		if (mode_q == CM_VECTOR) begin
			if (dir_pos) begin
				x_n = x_q + ys; y_n = y_q - xs; z_n = z_q + at;
			end else begin
				x_n = x_q - ys; y_n = y_q + xs; z_n = z_q - at;
			end
		end else begin
			if (dir_pos) begin
				x_n = x_q - ys; y_n = y_q + xs; z_n = z_q - at;
			end else begin
				x_n = x_q + ys; y_n = y_q - xs; z_n = z_q + at;
			end
		end
	end

	// Start values: vectoring scales by 2^16, rotation folds into +-pi/2.
	always_comb begin
		vx = DW'(signed'(req.vec_x)) <<< 16;
		vy = DW'(signed'(req.vec_y)) <<< 16;
		ang = {req.angle, 16'h0000};
		aflip = (ang >= 32'h4000_0000) && (ang < 32'hC000_0000);
		if (aflip) ang = ang + 32'h8000_0000;
	end

	// Iteration control and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				if (idx_q == IW'(NS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mode_q <= req.mode;
			if (req.mode == CM_VECTOR) begin
				flip_q <= 1'b0;
				if (vx < 0) begin
					x_q <= -vx; y_q <= -vy; z_q <= DW'(33'sh0_8000_0000);
				end else begin
					x_q <= vx; y_q <= vy; z_q <= '0;
				end
				// A zero vector is marked so the angle comes out as zero.
				if (req.vec_x == '0 && req.vec_y == '0) flip_q <= 1'b1;
			end else begin
				flip_q <= aflip;
				x_q <= CORDIC_K;
				y_q <= '0;
				z_q <= DW'(signed'(ang));
			end
		end else if (busy_q) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
		end
	end

	// Result rounding.
	always_comb begin
		zrnd = z_q[31:0] + 32'h0000_8000;
		cr = (x_q + DW'(32768)) >>> 16;
		sr = (y_q + DW'(32768)) >>> 16;
		if (flip_q) begin
			cr = -cr; sr = -sr;
		end
		rsp.done    = done_q;
		rsp.yaw     = (mode_q == CM_VECTOR && flip_q) ? 16'h0000 : zrnd[31:16];
		rsp.cos_q14 = cr[15:0];
		rsp.sin_q14 = sr[15:0];
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("CORDIC done without run");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start |=> busy_q || done_q) else $error("CORDIC lost run");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < IW'(NS)) else $error("CORDIC index out of range");

endmodule

// ===== src/gated_planar_odometry.sv =====
// ============================================================================
// gated_planar_odometry
// Command-gated planar odometry: CORDIC yaw, two delta rotations, saturation.
// ============================================================================
// A seed item and a still item take only the atan2 pass of the single shared
// CORDIC; a moving item then also takes both sine/cosine passes, which the
// shared CORDIC runs in turn after the atan2 pass.
// One item at a time; the input is ready again the cycle after the result is taken.
// Reset clears the filtered and last-seen pose and the seeded flag.
module gated_planar_odometry #(
	parameter int CORDIC_STEPS = 16,
	parameter int POS_WIDTH    = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // pos_x, pos_y, pos_z, rot_cos, rot_sin
	input  logic         s_tuser,  // moving
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,  // out_x, out_y, out_z, out_yaw
	output logic         m_tuser   // saturated
);
	import gpo_pkg::*;

	localparam int PW = (POS_WIDTH < 16) ? 16 : ((POS_WIDTH > 48) ? 48 : POS_WIDTH);
	localparam int WW = 52;
	localparam logic signed [WW-1:0] PMAX = WW'((64'sd1 <<< (PW - 1)) - 1);
	localparam logic signed [WW-1:0] PMIN = -PMAX - WW'(1);

	state_t state_q, state_d;
	logic   seeded_q;
	logic signed [31:0]   in_x_q, in_y_q, in_z_q;
	logic [15:0]          in_c_q, in_s_q;
	logic                 mov_q;
	logic [15:0]          ryaw_q;
	logic signed [31:0]   last_x_q, last_y_q, last_z_q;
	logic [15:0]          last_yaw_q;
	logic signed [PW-1:0] filt_x_q, filt_y_q, filt_z_q;
	logic [15:0]          filt_yaw_q;
	logic signed [WW-1:0] dx_q, dy_q, nx_q;
	logic signed [15:0]   c_q, s_q;
	logic                 sat_q;
	logic [1:0]           ph_q;
	logic signed [WW-1:0] acc_q, prod;
	logic signed [35:0]   mul_a;
	logic signed [15:0]   mul_b;
	cordic_req_t req;
	cordic_rsp_t rsp;

	gpo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	function automatic logic signed [WW-1:0] sat_fn(input logic signed [WW-1:0] v);
		if (v > PMAX) return PMAX;
		if (v < PMIN) return PMIN;
		return v;
	endfunction

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (s_tvalid) state_d = ST_ATAN;
			ST_ATAN:      state_d = ST_ATAN_WAIT;
			ST_ATAN_WAIT: if (rsp.done) state_d = !seeded_q ? ST_SEED :
			                             (mov_q ? ST_SC1 : ST_DONE);
			ST_SEED:      state_d = ST_DONE;
			ST_SC1:       state_d = ST_SC1_WAIT;
			ST_SC1_WAIT:  if (rsp.done) state_d = ST_ROT1;
			ST_ROT1:      if (ph_q == 2'd3) state_d = ST_SC2;
			ST_SC2:       state_d = ST_SC2_WAIT;
			ST_SC2_WAIT:  if (rsp.done) state_d = ST_ROT2;
			ST_ROT2:      if (ph_q == 2'd3) state_d = ST_SUM;
			ST_SUM:       state_d = ST_DONE;
			ST_DONE:      if (m_tready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Output and CORDIC request decode.
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		m_tvalid  = (state_q == ST_DONE);
		req.start = (state_q == ST_ATAN) || (state_q == ST_SC1) || (state_q == ST_SC2);
		req.mode  = (state_q == ST_ATAN) ? CM_VECTOR : CM_ROTATE;
		req.angle = (state_q == ST_SC1) ? (16'h0000 - last_yaw_q) : filt_yaw_q;
		req.vec_x = in_c_q;
		req.vec_y = in_s_q;
	end

	// Shared multiplier: one product per cycle over four phases.
	// Deltas stay within 35 bits through both rotations, so 36 x 16 is enough.
	always_comb begin
		unique case (ph_q)
			2'd0:    begin mul_a = 36'(dx_q); mul_b = c_q;  end
			2'd1:    begin mul_a = 36'(dy_q); mul_b = -s_q; end
			2'd2:    begin mul_a = 36'(dx_q); mul_b = s_q;  end
			default: begin mul_a = 36'(dy_q); mul_b = c_q;  end
		endcase
		prod = WW'(mul_a) * WW'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seeded_q <= 1'b0;
			last_x_q <= '0; last_y_q <= '0; last_z_q <= '0; last_yaw_q <= '0;
			filt_x_q <= '0; filt_y_q <= '0; filt_z_q <= '0; filt_yaw_q <= '0;
			ph_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROT1 || state_q == ST_ROT2) ph_q <= ph_q + 1'b1;
			else ph_q <= '0;
			if (state_q == ST_SEED) begin
				seeded_q <= 1'b1;
				filt_x_q <= PW'(sat_fn(WW'(in_x_q)));
				filt_y_q <= PW'(sat_fn(WW'(in_y_q)));
				filt_z_q <= PW'(sat_fn(WW'(in_z_q)));
				filt_yaw_q <= ryaw_q;
			end
			if (state_q == ST_SUM) begin
				filt_x_q <= PW'(sat_fn(WW'(filt_x_q) + dx_q));
				filt_y_q <= PW'(sat_fn(WW'(filt_y_q) + dy_q));
				filt_z_q <= PW'(sat_fn(WW'(filt_z_q) + WW'(in_z_q) - WW'(last_z_q)));
				filt_yaw_q <= filt_yaw_q + ryaw_q - last_yaw_q;
			end
			// The raw pose is recorded once the result is taken.
			if (state_q == ST_DONE && m_tready) begin
				last_x_q <= in_x_q;
				last_y_q <= in_y_q;
				last_z_q <= in_z_q;
				last_yaw_q <= ryaw_q;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			in_x_q <= s_tdata[31:0];
			in_y_q <= s_tdata[63:32];
			in_z_q <= s_tdata[95:64];
			in_c_q <= s_tdata[111:96];
			in_s_q <= s_tdata[127:112];
			mov_q  <= s_tuser;
			sat_q  <= 1'b0;
		end
		if (state_q == ST_ATAN_WAIT && rsp.done) begin
			ryaw_q <= rsp.yaw;
			dx_q <= WW'(in_x_q) - WW'(last_x_q);
			dy_q <= WW'(in_y_q) - WW'(last_y_q);
		end
		if ((state_q == ST_SC1_WAIT || state_q == ST_SC2_WAIT) && rsp.done) begin
			c_q <= rsp.cos_q14;
			s_q <= rsp.sin_q14;
		end
		// The new x is held aside until the new y has used the old x.
		if (state_q == ST_ROT1 || state_q == ST_ROT2) begin
			unique case (ph_q)
				2'd0: acc_q <= prod + WW'(8192);
				2'd1: nx_q <= (acc_q + prod) >>> 14;
				2'd2: acc_q <= prod + WW'(8192);
				default: begin
					dx_q <= nx_q;
					dy_q <= (acc_q + prod) >>> 14;
				end
			endcase
		end
		if (state_q == ST_SEED)
			sat_q <= (sat_fn(WW'(in_x_q)) != WW'(in_x_q)) ||
			         (sat_fn(WW'(in_y_q)) != WW'(in_y_q)) ||
			         (sat_fn(WW'(in_z_q)) != WW'(in_z_q));
		if (state_q == ST_SUM)
			sat_q <= (sat_fn(WW'(filt_x_q) + dx_q) != WW'(filt_x_q) + dx_q) ||
			         (sat_fn(WW'(filt_y_q) + dy_q) != WW'(filt_y_q) + dy_q) ||
			         (sat_fn(WW'(filt_z_q) + WW'(in_z_q) - WW'(last_z_q)) !=
			          WW'(filt_z_q) + WW'(in_z_q) - WW'(last_z_q));
	end

	assign m_tdata = {filt_yaw_q, 32'(filt_z_q), 32'(filt_y_q), 32'(filt_x_q)};
	assign m_tuser = sat_q;

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input and output open together");
	a_seed_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEED |-> !seeded_q) else $error("seed on seeded filter");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_SEED || $past(state_q) == ST_SUM ||
		$past(state_q) == ST_ATAN_WAIT) else $error("result from wrong state");

endmodule
